// ----- rtl/dasd_pkg.sv -----
// Shared constants, codes and calendar helper functions for the date adder.
// No dependencies; every other file of the block uses this package.
package dasd_pkg;

    // Default widths of the offset and year fields.
    localparam int OFFSET_BITS_DEF = 16;
    localparam int YEAR_BITS_DEF   = 14;

    // Upper bound on the year besides the field width.
    localparam int YEAR_LIMIT = 9999;

    // Depth of the queue between the classifier and the stepper.
    localparam int QUEUE_DEPTH = 2;

    // Reciprocal multiply for year / 25, exact for years below 2^16.
    localparam int          YEAR_CALC_BITS = 16;
    localparam int          MOD25_SHIFT    = 21;
    localparam int          QUOT_BITS      = 12;
    localparam int          PROD_BITS      = 33;
    localparam logic [16:0] MOD25_MUL      = 17'd83887;

    // Work kind decided by the front end for each item.
    localparam logic [1:0] KIND_INVALID = 2'd0;
    localparam logic [1:0] KIND_HOLD    = 2'd1;
    localparam logic [1:0] KIND_FWD     = 2'd2;
    localparam logic [1:0] KIND_BWD     = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    // Largest legal year for a given year field width.
    function automatic int year_max(input int yb);
        int full;
        begin
            full = (1 << yb) - 1;
            return (full < YEAR_LIMIT) ? full : YEAR_LIMIT;
        end
    endfunction

    // Gregorian leap rule from the low year bits and the year modulo 25.
    // A year divisible by 4 is a leap year unless it is a century that is
    // not divisible by 400; century means divisible by 4 and by 25.
    function automatic logic leap_year(input logic [3:0] yr_lo, input logic [4:0] r25);
        begin
            return (yr_lo[1:0] == 2'd0) && ((r25 != 5'd0) || (yr_lo == 4'd0));
        end
    endfunction

    // Days in a month; months outside 1..12 have no days.
    function automatic logic [4:0] days_of_month(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon)
                4'd1:    len = 5'd31;
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd3:    len = 5'd31;
                4'd4:    len = 5'd30;
                4'd5:    len = 5'd31;
                4'd6:    len = 5'd30;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd31;
                4'd9:    len = 5'd30;
                4'd10:   len = 5'd31;
                4'd11:   len = 5'd30;
                4'd12:   len = 5'd31;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Year modulo 25 after a step up or down by one year.
    function automatic logic [4:0] r25_inc(input logic [4:0] r25);
        begin
            return (r25 == 5'd24) ? 5'd0 : r25 + 5'd1;
        end
    endfunction

    function automatic logic [4:0] r25_dec(input logic [4:0] r25);
        begin
            return (r25 == 5'd0) ? 5'd24 : r25 - 5'd1;
        end
    endfunction

endpackage

// ----- rtl/dasd_if.sv -----
// Valid/ready channel interfaces for the request and response beats.
// Depends on dasd_pkg for the default field widths.
interface dasd_req_if #(
    parameter int OFFSET_BITS = dasd_pkg::OFFSET_BITS_DEF,
    parameter int YEAR_BITS   = dasd_pkg::YEAR_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [4:0]             in_day;
    logic [3:0]             in_month;
    logic [YEAR_BITS-1:0]   in_year;
    logic [OFFSET_BITS-1:0] offset_days;

    modport source (output valid, in_day, in_month, in_year, offset_days, input ready);
    modport sink   (input valid, in_day, in_month, in_year, offset_days, output ready);
endinterface

interface dasd_rsp_if #(
    parameter int YEAR_BITS = dasd_pkg::YEAR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [4:0]           out_day;
    logic [3:0]           out_month;
    logic [YEAR_BITS-1:0] out_year;
    logic [1:0]           status;

    modport source (output valid, out_day, out_month, out_year, status, input ready);
    modport sink   (input valid, out_day, out_month, out_year, status, output ready);
endinterface

// ----- rtl/date_add_signed_days.sv -----
// Top level of the Gregorian date adder: front end, queue and month stepper.
// Depends on dasd_pkg, dasd_if, dasd_front, dasd_queue and dasd_back.
//
//   Channel | Direction | Beat contents
//   --------+-----------+-----------------------------------------------
//   req     | in        | in_day, in_month, in_year, offset_days
//   rsp     | out       | out_day, out_month, out_year, status
//
// The front end takes one request at a time: it accepts it, forms the year/25
// quotient, then checks and classifies it. The back end loads an item, steps it
// month by month (the last step ends in the month where the offset runs out or at
// the year limit; items with a zero offset or an invalid date take no step), and
// then moves the result into the response register. Reset clears all control state.
// Each side stalls on its own behind the two-entry queue.
module date_add_signed_days #(
    parameter int OFFSET_BITS = dasd_pkg::OFFSET_BITS_DEF,
    parameter int YEAR_BITS   = dasd_pkg::YEAR_BITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    dasd_req_if.sink   req,
    dasd_rsp_if.source rsp
);
    import dasd_pkg::*;

    localparam int ITEM_BITS = 5 + 4 + YEAR_BITS + 5 + OFFSET_BITS + 2;

    logic                 push_valid, push_ready;
    logic [ITEM_BITS-1:0] push_data;
    logic                 pop_valid, pop_ready;
    logic [ITEM_BITS-1:0] pop_data;

    // Validation and classification.
    dasd_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .YEAR_BITS   (YEAR_BITS),
        .ITEM_BITS   (ITEM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue.
    dasd_queue #(
        .WIDTH (ITEM_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    // Month stepper and response register.
    dasd_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .YEAR_BITS   (YEAR_BITS),
        .ITEM_BITS   (ITEM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/dasd_front.sv -----
// Front end: accepts a request beat, validates the date and classifies the work.
// Depends on dasd_pkg and dasd_req_if; pushes packed items into the queue.
module dasd_front #(
    parameter int OFFSET_BITS = dasd_pkg::OFFSET_BITS_DEF,
    parameter int YEAR_BITS   = dasd_pkg::YEAR_BITS_DEF,
    parameter int ITEM_BITS   = 5 + 4 + dasd_pkg::YEAR_BITS_DEF + 5
                                + dasd_pkg::OFFSET_BITS_DEF + 2
)(
    input  logic                 clk,
    input  logic                 rst_n,
    dasd_req_if.sink             req,
    output logic                 push_valid,
    input  logic                 push_ready,
    output logic [ITEM_BITS-1:0] push_data
);
    import dasd_pkg::*;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX = YEAR_BITS'(year_max(YEAR_BITS));

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_QUOT  = 2'd1;
    localparam logic [1:0] F_CLASS = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [4:0]             day_reg;
    logic [3:0]             mon_reg;
    logic [YEAR_BITS-1:0]   yr_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [QUOT_BITS-1:0]   quot_reg;

    logic [YEAR_CALC_BITS-1:0] yr_wide;
    logic [PROD_BITS-1:0]      prod;
    logic [YEAR_CALC_BITS-1:0] quot_x25;
    logic [YEAR_CALC_BITS-1:0] yr_rem;
    logic [4:0]                r25;
    logic                      leap;
    logic [4:0]                mlen;
    logic                      date_ok;
    logic [OFFSET_BITS-1:0]    mag;
    logic [1:0]                kind;

    assign req.ready = (state_reg == F_IDLE);

    // Quotient of year by 25 through the reciprocal multiply.
    assign yr_wide = YEAR_CALC_BITS'(yr_reg);
    assign prod    = PROD_BITS'(yr_wide) * PROD_BITS'(MOD25_MUL);

    // Remainder from the registered quotient: year - 16q - 8q - q.
    assign quot_x25 = (YEAR_CALC_BITS'(quot_reg) << 4) + (YEAR_CALC_BITS'(quot_reg) << 3)
                      + YEAR_CALC_BITS'(quot_reg);
    assign yr_rem   = yr_wide - quot_x25;
    assign r25      = yr_rem[4:0];

    // Date check and work classification.
    assign leap    = leap_year(yr_reg[3:0], r25);
    assign mlen    = days_of_month(mon_reg, leap);
    assign date_ok = (mon_reg >= 4'd1) && (mon_reg <= 4'd12)
                     && (yr_reg != '0) && (yr_reg <= YEAR_MAX)
                     && (day_reg != 5'd0) && (day_reg <= mlen);
    assign mag     = off_reg[OFFSET_BITS-1] ? (~off_reg + 1'b1) : off_reg;

    always_comb
    begin
        if (!date_ok)
            kind = KIND_INVALID;
        else if (off_reg == '0)
            kind = KIND_HOLD;
        else if (off_reg[OFFSET_BITS-1])
            kind = KIND_BWD;
        else
            kind = KIND_FWD;
    end

    assign push_valid = (state_reg == F_CLASS);
    assign push_data  = {day_reg, mon_reg, yr_reg, r25, mag, kind};

    // Sequencer: accept, form the quotient, then classify and push.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req.valid)
                    state_next = F_QUOT;
            end
            F_QUOT:
            begin
                state_next = F_CLASS;
            end
            F_CLASS:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Held request fields and the quotient register.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            day_reg <= req.in_day;
            mon_reg <= req.in_month;
            yr_reg  <= req.in_year;
            off_reg <= req.offset_days;
        end
        if (state_reg == F_QUOT)
            quot_reg <= prod[MOD25_SHIFT +: QUOT_BITS];
    end

endmodule

// ----- rtl/dasd_queue.sv -----
// Small register queue that decouples the classifier from the stepper.
// No dependencies besides dasd_pkg for its default depth.
module dasd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dasd_pkg::QUEUE_DEPTH
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import dasd_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- rtl/dasd_back.sv -----
// Back end: steps the date month by month and registers the response beat.
// Depends on dasd_pkg and dasd_rsp_if; pops packed items from the queue.
module dasd_back #(
    parameter int OFFSET_BITS = dasd_pkg::OFFSET_BITS_DEF,
    parameter int YEAR_BITS   = dasd_pkg::YEAR_BITS_DEF,
    parameter int ITEM_BITS   = 5 + 4 + dasd_pkg::YEAR_BITS_DEF + 5
                                + dasd_pkg::OFFSET_BITS_DEF + 2
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [ITEM_BITS-1:0] pop_data,
    dasd_rsp_if.source           rsp
);
    import dasd_pkg::*;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX = YEAR_BITS'(year_max(YEAR_BITS));
    localparam logic [YEAR_BITS-1:0] YEAR_ONE = YEAR_BITS'(1);
    localparam int CW = OFFSET_BITS + 6;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_DONE = 2'd2;

    // Fields of the queued item.
    logic [4:0]             q_day;
    logic [3:0]             q_mon;
    logic [YEAR_BITS-1:0]   q_yr;
    logic [4:0]             q_r25;
    logic [OFFSET_BITS-1:0] q_mag;
    logic [1:0]             q_kind;

    assign {q_day, q_mon, q_yr, q_r25, q_mag, q_kind} = pop_data;

    logic [1:0]             state_reg, state_next;
    logic [4:0]             day_reg, day_next;
    logic [3:0]             mon_reg, mon_next;
    logic [YEAR_BITS-1:0]   yr_reg, yr_next;
    logic [4:0]             r25_reg, r25_next;
    logic [OFFSET_BITS-1:0] t_reg, t_next;
    logic                   dir_reg;
    logic [1:0]             status_reg, status_next;
    logic                   finish;

    logic                   out_valid_reg;
    logic [4:0]             out_day_reg;
    logic [3:0]             out_month_reg;
    logic [YEAR_BITS-1:0]   out_year_reg;
    logic [1:0]             out_status_reg;
    logic                   out_free;

    logic [4:0]             cur_len;
    logic [CW-1:0]          t_ext, day_ext, rem_ext;
    logic [CW-1:0]          t_diff;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign pop_ready = (state_reg == B_IDLE);

    assign cur_len = days_of_month(mon_reg, leap_year(yr_reg[3:0], r25_reg));
    assign t_ext   = CW'(t_reg);
    assign day_ext = CW'(day_reg);
    assign rem_ext = CW'(cur_len) - day_ext + CW'(1);
    assign t_diff  = t_ext - (dir_reg ? day_ext : rem_ext);

    // One month step in the chosen direction.
    always_comb
    begin
        day_next    = day_reg;
        mon_next    = mon_reg;
        yr_next     = yr_reg;
        r25_next    = r25_reg;
        t_next      = t_reg;
        status_next = status_reg;
        finish      = 1'b0;
        if (!dir_reg)
        begin
            // Forward: finish inside this month or move to the first of the next, stopping at 31 December of YEAR_MAX.
            if (rem_ext > t_ext)
            begin
                day_next = 5'(day_ext + t_ext);
                t_next   = '0;
                finish   = 1'b1;
            end
            else
            begin
                t_next   = OFFSET_BITS'(t_diff);
                day_next = 5'd1;
                finish   = (t_diff == '0);
                if (mon_reg == 4'd12)
                begin
                    if (yr_reg == YEAR_MAX)
                    begin
                        day_next    = 5'd31;
                        mon_next    = 4'd12;
                        status_next = STATUS_RANGE;
                        finish      = 1'b1;
                    end
                    else
                    begin
                        mon_next = 4'd1;
                        yr_next  = yr_reg + 1'b1;
                        r25_next = r25_inc(r25_reg);
                    end
                end
                else
                begin
                    mon_next = mon_reg + 4'd1;
                end
            end
        end
        else
        begin
            // Backward: finish inside this month or move to the last of the previous, stopping at 1 January of year 1.
            if (day_ext > t_ext)
            begin
                day_next = 5'(day_ext - t_ext);
                t_next   = '0;
                finish   = 1'b1;
            end
            else
            begin
                t_next = OFFSET_BITS'(t_diff);
                finish = (t_diff == '0);
                if (mon_reg <= 4'd1)
                begin
                    if (yr_reg <= YEAR_ONE)
                    begin
                        day_next    = 5'd1;
                        mon_next    = 4'd1;
                        yr_next     = YEAR_ONE;
                        status_next = STATUS_RANGE;
                        finish      = 1'b1;
                    end
                    else
                    begin
                        mon_next = 4'd12;
                        yr_next  = yr_reg - 1'b1;
                        r25_next = r25_dec(r25_reg);
                        day_next = days_of_month(4'd12, 1'b0);
                    end
                end
                else
                begin
                    mon_next = mon_reg - 4'd1;
                    day_next = days_of_month(mon_reg - 4'd1,
                                             leap_year(yr_reg[3:0], r25_reg));
                end
            end
        end
    end

    // Control sequencer of the stepper.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    if (q_kind == KIND_FWD || q_kind == KIND_BWD)
                        state_next = B_RUN;
                    else
                        state_next = B_DONE;
                end
            end
            B_RUN:
            begin
                if (finish)
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working date registers and the response register.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid)
        begin
            day_reg    <= q_day;
            mon_reg    <= q_mon;
            yr_reg     <= q_yr;
            r25_reg    <= q_r25;
            t_reg      <= q_mag;
            dir_reg    <= (q_kind == KIND_BWD);
            status_reg <= (q_kind == KIND_INVALID) ? STATUS_INVALID : STATUS_OK;
        end
        else if (state_reg == B_RUN)
        begin
            day_reg    <= day_next;
            mon_reg    <= mon_next;
            yr_reg     <= yr_next;
            r25_reg    <= r25_next;
            t_reg      <= t_next;
            status_reg <= status_next;
        end
        if (state_reg == B_DONE && out_free)
        begin
            out_day_reg    <= day_reg;
            out_month_reg  <= mon_reg;
            out_year_reg   <= yr_reg;
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_day   = out_day_reg;
    assign rsp.out_month = out_month_reg;
    assign rsp.out_year  = out_year_reg;
    assign rsp.status    = out_status_reg;

endmodule
